### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked assertion, off while reset is asserted
`define SPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked assertion that also holds through reset
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/h264sps_pkg.sv
// ----------------------------------------------------------------------------
// h264sps_pkg
// Constants and types for the H.264 SPS frame size parser.
// ----------------------------------------------------------------------------
package h264sps_pkg;

    // longest Exp-Golomb prefix that is still decoded
    localparam int MAX_PREFIX_ZEROS = 31;
    localparam int PZ_W             = $clog2(MAX_PREFIX_ZEROS + 1);
    localparam int CODE_W           = 32;

    // size datapath: signed, holds (h+1)*32 less the crop terms
    localparam int ACC_W            = CODE_W + 7;
    localparam int SIZE_W           = 16;

    localparam int MB_SHIFT         = 4;
    localparam int MB_SIZE          = 16;
    localparam logic [7:0] PROFILE_RESET = 8'd66;

    localparam int NAL_W            = 8;
    localparam int OUT_BITS         = 2 + 2 * SIZE_W;
    localparam int OUT_TDATA_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_PROFILE   = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        PH_HEADER         = 5'd0,
        PH_SPS_ID         = 5'd1,
        PH_LOG2_FRAME_NUM = 5'd2,
        PH_POC_TYPE       = 5'd3,
        PH_POC_LSB        = 5'd4,
        PH_DELTA_ZERO     = 5'd5,
        PH_OFF_NONREF     = 5'd6,
        PH_OFF_TOPBOT     = 5'd7,
        PH_NUM_CYCLE      = 5'd8,
        PH_REF_OFFSET     = 5'd9,
        PH_MAX_REFS       = 5'd10,
        PH_GAPS           = 5'd11,
        PH_WIDTH          = 5'd12,
        PH_HEIGHT         = 5'd13,
        PH_FRAMES_ONLY    = 5'd14,
        PH_MBAFF          = 5'd15,
        PH_DIRECT         = 5'd16,
        PH_CROP_FLAG      = 5'd17,
        PH_CROP_L         = 5'd18,
        PH_CROP_R         = 5'd19,
        PH_CROP_T         = 5'd20,
        PH_CROP_B         = 5'd21,
        PH_DONE           = 5'd22
    } t_phase;

endpackage

### rtl/h264_sps_frame_size_parser_top.sv
// ----------------------------------------------------------------------------
// h264_sps_frame_size_parser_top
// Bit-serial Exp-Golomb parser that pulls the cropped frame size out of an
// H.264 SPS NAL unit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one NAL byte per beat, header byte first, tlast on the
//   final byte. Master stream: one beat per NAL unit with the status and the
//   cropped width and height. Config channel: one write sets the accepted
//   profile byte (66 after reset); o_cfg_ready is always high.
//   Timing: each of the four header bytes is accepted, then wrapped up.
//   Every later byte is accepted, then takes one bit per cycle through the
//   shared Exp-Golomb bit unit, then is wrapped up; bits after the outcome
//   are skipped. The byte that completes the size adds the steps on the
//   shared 39-bit adder (crop sum, subtract, offset, for width then height).
//   A result then passes through S_EMIT into the output register.
//   o_s_tready is high only between bytes.
//   Stall: the output register holds a result while a byte is parsed; a
//   second result waits inside the block, input not ready, until the
//   master side takes the first.
//   Reset: synchronous, active low; clears the parse state and the output
//   valid and restores the profile register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h264_sps_frame_size_parser_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [7:0]                           i_cfg_data,   // required_profile
    // byte stream in
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [h264sps_pkg::NAL_W-1:0]        i_s_tdata,    // [7:0] nal_byte
    input  logic                                 i_s_tlast,    // last_byte
    // result stream out
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [1:0] status, [17:2] frame_width, [33:18] frame_height, rest zero
    output logic [h264sps_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BITS,
        S_SIZE,
        S_END,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SZ_W_SUM,
        SZ_W_DIFF,
        SZ_W_ADD,
        SZ_H_SUM,
        SZ_H_DIFF,
        SZ_H_ADD
    } t_size_step;

    localparam int CW = h264sps_pkg::CODE_W;
    localparam int AW = h264sps_pkg::ACC_W;
    localparam int SW = h264sps_pkg::SIZE_W;

    t_state                      r_state,  n_state;
    logic [7:0]                  r_profile, n_profile;
    logic [7:0]                  r_byte,   n_byte;
    logic                        r_last,   n_last;
    logic [1:0]                  r_hdr,    n_hdr;
    h264sps_pkg::t_phase         r_phase,  n_phase;
    logic [h264sps_pkg::PZ_W-1:0] r_pz,    n_pz;
    logic [CW-1:0]               r_code,   n_code;
    logic [2:0]                  r_bit,    n_bit;
    logic [CW-1:0]               r_ref,    n_ref;
    logic [CW-1:0]               r_wm1,    n_wm1;
    logic [CW-1:0]               r_hm1,    n_hm1;
    logic                        r_fo,     n_fo;
    logic [CW-1:0]               r_cl,     n_cl;
    logic [CW-1:0]               r_cr,     n_cr;
    logic [CW-1:0]               r_ct,     n_ct;
    logic [CW-1:0]               r_cb,     n_cb;
    logic                        r_given,  n_given;
    t_size_step                  r_step,   n_step;
    logic [AW-1:0]               r_acc,    n_acc;
    logic                        r_w_ok,   n_w_ok;
    logic                        r_res_new, n_res_new;
    h264sps_pkg::t_status        r_res_st, n_res_st;
    logic [SW-1:0]               r_res_w,  n_res_w;
    logic [SW-1:0]               r_res_h,  n_res_h;
    logic                        r_out_valid, n_out_valid;
    h264sps_pkg::t_status        r_out_st, n_out_st;
    logic [SW-1:0]               r_out_w,  n_out_w;
    logic [SW-1:0]               r_out_h,  n_out_h;

    // bit unit
    logic                        w_b;
    logic                        w_done;
    logic                        w_fail;
    logic [CW-1:0]               w_shift;
    logic [CW-1:0]               w_v;
    // size adder
    logic [AW-1:0]               w_a;
    logic [AW-1:0]               w_bop;
    logic                        w_cin;
    logic [AW-1:0]               w_sum;
    logic                        w_fit;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = h264sps_pkg::OUT_TDATA_W'({r_out_h, r_out_w, r_out_st});

    // Exp-Golomb bit step; code 0 means the prefix is still being read
    always_comb begin
        w_b     = r_byte[3'd7 - r_bit];
        w_done  = 1'b0;
        w_fail  = 1'b0;
        w_shift = {r_code[CW-2:0], w_b};
        w_v     = CW'(w_b);
        if (!(r_phase inside {h264sps_pkg::PH_DELTA_ZERO, h264sps_pkg::PH_GAPS,
                              h264sps_pkg::PH_FRAMES_ONLY, h264sps_pkg::PH_MBAFF,
                              h264sps_pkg::PH_DIRECT, h264sps_pkg::PH_CROP_FLAG})) begin
            if (r_code == '0) begin
                w_v = '0;
                if (!w_b) begin
                    w_fail = (r_pz ==
                              h264sps_pkg::PZ_W'(h264sps_pkg::MAX_PREFIX_ZEROS));
                end else begin
                    w_done = (r_pz == '0);
                end
            end else begin
                w_v    = w_shift - CW'(1);
                w_done = (r_pz == h264sps_pkg::PZ_W'(1));
            end
        end else begin
            w_done = 1'b1;
        end
    end

    // shared size adder: a + b + cin
    always_comb begin
        w_a   = '0;
        w_bop = '0;
        w_cin = 1'b0;
        case (r_step)
            SZ_W_SUM: begin
                w_a   = AW'(r_cl);
                w_bop = AW'(r_cr);
            end
            SZ_W_DIFF: begin
                w_a   = AW'({r_wm1, {h264sps_pkg::MB_SHIFT{1'b0}}});
                w_bop = ~(r_acc << 1);
                w_cin = 1'b1;
            end
            SZ_W_ADD: begin
                w_a   = r_acc;
                w_bop = AW'(h264sps_pkg::MB_SIZE);
            end
            SZ_H_SUM: begin
                w_a   = AW'(r_ct);
                w_bop = AW'(r_cb);
            end
            SZ_H_DIFF: begin
                // field coding doubles the height units
                w_a   = r_fo ? AW'({r_hm1, {h264sps_pkg::MB_SHIFT{1'b0}}})
                             : AW'({r_hm1, {(h264sps_pkg::MB_SHIFT + 1){1'b0}}});
                w_bop = ~(r_acc << 1);
                w_cin = 1'b1;
            end
            SZ_H_ADD: begin
                w_a   = r_acc;
                w_bop = r_fo ? AW'(h264sps_pkg::MB_SIZE) : AW'(2 * h264sps_pkg::MB_SIZE);
            end
            default: begin
                w_a   = '0;
                w_bop = '0;
            end
        endcase
        w_sum = w_a + w_bop + AW'(w_cin);
        w_fit = !w_sum[AW-1] && (w_sum[AW-2:SW] == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_profile   = r_profile;
        n_byte      = r_byte;
        n_last      = r_last;
        n_hdr       = r_hdr;
        n_phase     = r_phase;
        n_pz        = r_pz;
        n_code      = r_code;
        n_bit       = r_bit;
        n_ref       = r_ref;
        n_wm1       = r_wm1;
        n_hm1       = r_hm1;
        n_fo        = r_fo;
        n_cl        = r_cl;
        n_cr        = r_cr;
        n_ct        = r_ct;
        n_cb        = r_cb;
        n_given     = r_given;
        n_step      = r_step;
        n_acc       = r_acc;
        n_w_ok      = r_w_ok;
        n_res_new   = r_res_new;
        n_res_st    = r_res_st;
        n_res_w     = r_res_w;
        n_res_h     = r_res_h;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_st    = r_out_st;
        n_out_w     = r_out_w;
        n_out_h     = r_out_h;

        if (i_cfg_valid) begin
            n_profile = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_byte = i_s_tdata;
                    n_last = i_s_tlast;
                    n_bit  = '0;
                    if (r_phase == h264sps_pkg::PH_HEADER) begin
                        n_state = S_END;
                        if (!i_s_tlast) begin
                            if (r_hdr == 2'd1 && i_s_tdata != r_profile) begin
                                n_res_new = 1'b1;
                                n_res_st  = h264sps_pkg::ST_PROFILE;
                                n_res_w   = '0;
                                n_res_h   = '0;
                                n_given   = 1'b1;
                                n_phase   = h264sps_pkg::PH_DONE;
                            end else if (r_hdr == 2'd3) begin
                                n_hdr   = '0;
                                n_phase = h264sps_pkg::PH_SPS_ID;
                            end else begin
                                n_hdr = r_hdr + 2'd1;
                            end
                        end
                    end else begin
                        n_state = S_BITS;
                    end
                end
            end

            S_BITS: begin
                if (r_phase == h264sps_pkg::PH_DONE) begin
                    n_state = S_END;
                    n_bit   = '0;
                end else begin
                    n_bit = r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        n_state = S_END;
                    end
                    if (w_fail) begin
                        n_res_new = 1'b1;
                        n_res_st  = h264sps_pkg::ST_RANGE;
                        n_res_w   = '0;
                        n_res_h   = '0;
                        n_given   = 1'b1;
                        n_phase   = h264sps_pkg::PH_DONE;
                        n_state   = S_END;
                        n_bit     = '0;
                    end else if (!w_done) begin
                        if (r_code == '0) begin
                            if (w_b) begin
                                n_code = CW'(1);
                            end else begin
                                n_pz = r_pz + h264sps_pkg::PZ_W'(1);
                            end
                        end else begin
                            n_code = w_shift;
                            n_pz   = r_pz - h264sps_pkg::PZ_W'(1);
                        end
                    end else begin
                        n_code = '0;
                        n_pz   = '0;
                        case (r_phase)
                            h264sps_pkg::PH_SPS_ID:         n_phase = h264sps_pkg::PH_LOG2_FRAME_NUM;
                            h264sps_pkg::PH_LOG2_FRAME_NUM: n_phase = h264sps_pkg::PH_POC_TYPE;
                            h264sps_pkg::PH_POC_TYPE: begin
                                if (w_v == '0) begin
                                    n_phase = h264sps_pkg::PH_POC_LSB;
                                end else if (w_v == CW'(1)) begin
                                    n_phase = h264sps_pkg::PH_DELTA_ZERO;
                                end else begin
                                    n_phase = h264sps_pkg::PH_MAX_REFS;
                                end
                            end
                            h264sps_pkg::PH_POC_LSB:    n_phase = h264sps_pkg::PH_MAX_REFS;
                            h264sps_pkg::PH_DELTA_ZERO: n_phase = h264sps_pkg::PH_OFF_NONREF;
                            h264sps_pkg::PH_OFF_NONREF: n_phase = h264sps_pkg::PH_OFF_TOPBOT;
                            h264sps_pkg::PH_OFF_TOPBOT: n_phase = h264sps_pkg::PH_NUM_CYCLE;
                            h264sps_pkg::PH_NUM_CYCLE: begin
                                n_ref   = w_v;
                                n_phase = (w_v == '0) ? h264sps_pkg::PH_MAX_REFS
                                                      : h264sps_pkg::PH_REF_OFFSET;
                            end
                            h264sps_pkg::PH_REF_OFFSET: begin
                                n_ref = r_ref - CW'(1);
                                if (r_ref == CW'(1)) begin
                                    n_phase = h264sps_pkg::PH_MAX_REFS;
                                end
                            end
                            h264sps_pkg::PH_MAX_REFS: n_phase = h264sps_pkg::PH_GAPS;
                            h264sps_pkg::PH_GAPS:     n_phase = h264sps_pkg::PH_WIDTH;
                            h264sps_pkg::PH_WIDTH: begin
                                n_wm1   = w_v;
                                n_phase = h264sps_pkg::PH_HEIGHT;
                            end
                            h264sps_pkg::PH_HEIGHT: begin
                                n_hm1   = w_v;
                                n_phase = h264sps_pkg::PH_FRAMES_ONLY;
                            end
                            h264sps_pkg::PH_FRAMES_ONLY: begin
                                n_fo    = w_v[0];
                                n_phase = w_v[0] ? h264sps_pkg::PH_DIRECT
                                                 : h264sps_pkg::PH_MBAFF;
                            end
                            h264sps_pkg::PH_MBAFF:  n_phase = h264sps_pkg::PH_DIRECT;
                            h264sps_pkg::PH_DIRECT: n_phase = h264sps_pkg::PH_CROP_FLAG;
                            h264sps_pkg::PH_CROP_FLAG: begin
                                if (w_v[0]) begin
                                    n_phase = h264sps_pkg::PH_CROP_L;
                                end else begin
                                    n_state = S_SIZE;
                                    n_step  = SZ_W_SUM;
                                end
                            end
                            h264sps_pkg::PH_CROP_L: begin
                                n_cl    = w_v;
                                n_phase = h264sps_pkg::PH_CROP_R;
                            end
                            h264sps_pkg::PH_CROP_R: begin
                                n_cr    = w_v;
                                n_phase = h264sps_pkg::PH_CROP_T;
                            end
                            h264sps_pkg::PH_CROP_T: begin
                                n_ct    = w_v;
                                n_phase = h264sps_pkg::PH_CROP_B;
                            end
                            h264sps_pkg::PH_CROP_B: begin
                                n_cb    = w_v;
                                n_state = S_SIZE;
                                n_step  = SZ_W_SUM;
                            end
                            default: n_phase = h264sps_pkg::PH_DONE;
                        endcase
                        if (n_state == S_SIZE) begin
                            n_bit = '0;
                        end
                    end
                end
            end

            S_SIZE: begin
                n_acc = w_sum;
                case (r_step)
                    SZ_W_SUM:  n_step = SZ_W_DIFF;
                    SZ_W_DIFF: n_step = SZ_W_ADD;
                    SZ_W_ADD: begin
                        n_w_ok  = w_fit;
                        n_res_w = w_sum[SW-1:0];
                        n_step  = SZ_H_SUM;
                    end
                    SZ_H_SUM:  n_step = SZ_H_DIFF;
                    SZ_H_DIFF: n_step = SZ_H_ADD;
                    SZ_H_ADD: begin
                        n_res_new = 1'b1;
                        n_given   = 1'b1;
                        n_phase   = h264sps_pkg::PH_DONE;
                        n_state   = S_END;
                        if (r_w_ok && w_fit) begin
                            n_res_st = h264sps_pkg::ST_OK;
                            n_res_h  = w_sum[SW-1:0];
                        end else begin
                            n_res_st = h264sps_pkg::ST_RANGE;
                            n_res_w  = '0;
                            n_res_h  = '0;
                        end
                    end
                    default: n_step = SZ_W_SUM;
                endcase
            end

            S_END: begin
                if (r_last) begin
                    if (!r_given) begin
                        n_res_new = 1'b1;
                        n_res_st  = h264sps_pkg::ST_TRUNCATED;
                        n_res_w   = '0;
                        n_res_h   = '0;
                    end
                    // new NAL unit starts
                    n_hdr   = '0;
                    n_phase = h264sps_pkg::PH_HEADER;
                    n_pz    = '0;
                    n_code  = '0;
                    n_ref   = '0;
                    n_wm1   = '0;
                    n_hm1   = '0;
                    n_fo    = 1'b0;
                    n_cl    = '0;
                    n_cr    = '0;
                    n_ct    = '0;
                    n_cb    = '0;
                    n_given = 1'b0;
                end
                n_bit   = '0;
                n_state = n_res_new ? S_EMIT : S_IDLE;
            end

            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_w     = r_res_w;
                    n_out_h     = r_res_h;
                    n_res_new   = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_profile   <= h264sps_pkg::PROFILE_RESET;
            r_last      <= 1'b0;
            r_hdr       <= '0;
            r_phase     <= h264sps_pkg::PH_HEADER;
            r_pz        <= '0;
            r_code      <= '0;
            r_bit       <= '0;
            r_ref       <= '0;
            r_wm1       <= '0;
            r_hm1       <= '0;
            r_fo        <= 1'b0;
            r_cl        <= '0;
            r_cr        <= '0;
            r_ct        <= '0;
            r_cb        <= '0;
            r_given     <= 1'b0;
            r_step      <= SZ_W_SUM;
            r_res_new   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_profile   <= n_profile;
            r_last      <= n_last;
            r_hdr       <= n_hdr;
            r_phase     <= n_phase;
            r_pz        <= n_pz;
            r_code      <= n_code;
            r_bit       <= n_bit;
            r_ref       <= n_ref;
            r_wm1       <= n_wm1;
            r_hm1       <= n_hm1;
            r_fo        <= n_fo;
            r_cl        <= n_cl;
            r_cr        <= n_cr;
            r_ct        <= n_ct;
            r_cb        <= n_cb;
            r_given     <= n_given;
            r_step      <= n_step;
            r_res_new   <= n_res_new;
            r_out_valid <= n_out_valid;
        end
        // datapath, no reset
        r_byte   <= n_byte;
        r_acc    <= n_acc;
        r_w_ok   <= n_w_ok;
        r_res_st <= n_res_st;
        r_res_w  <= n_res_w;
        r_res_h  <= n_res_h;
        r_out_st <= n_out_st;
        r_out_w  <= n_out_w;
        r_out_h  <= n_out_h;
    end

    `SPS_ASSERT(a_ready_no_pending, i_clk, i_rst_n, o_s_tready |-> !r_res_new, "input ready with a result still pending")
    `SPS_ASSERT(a_busy_after_beat, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "ready right after an accepted beat")
    `SPS_ASSERT(a_given_done, i_clk, i_rst_n, r_given |-> (r_phase == h264sps_pkg::PH_DONE), "result given but parse not finished")
    `SPS_ASSERT(a_size_phase, i_clk, i_rst_n, (r_state == S_SIZE) |-> (r_phase == h264sps_pkg::PH_CROP_FLAG || r_phase == h264sps_pkg::PH_CROP_B), "size check outside a cropping phase")
    `SPS_ASSERT(a_emit_loads, i_clk, i_rst_n, (r_state == S_EMIT && (!r_out_valid || i_m_tready)) |=> o_m_tvalid, "pending result not moved to output")
    `SPS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule
